FILE: rtl/cor_pkg.sv
// Shared widths, codes and small helper functions for the circle octant rasterizer.
// No dependencies; imported by every module of the block.
package cor_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;
    localparam int OUT_BITS    = COORD_BITS + 1;
    localparam int DEC_BITS    = RADIUS_BITS + 4;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_BITS  = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

    // decision constants of the midpoint rule
    localparam int DEC_START   = 3;
    localparam int DEC_STEP_E  = 6;
    localparam int DEC_STEP_SE = 10;

    // func codes carried on s_tuser
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        JOB_ZERO,   // zero radius: center only
        JOB_START,  // four axis points
        JOB_STEP    // eight mirrored octant points
    } cor_job_kind_t;

    typedef struct packed {
        cor_job_kind_t kind;
        logic [2:0]    cnt;
        logic          fin;
    } cor_job_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] px;
        logic [OUT_BITS-1:0] py;
        logic                last;
        logic                done;
    } cor_pixel_t;

    // index of the final pixel of a job
    function automatic logic [2:0] cor_last_cnt(cor_job_kind_t kind);
        logic [2:0] res;
        case (kind)
            JOB_ZERO:  res = 3'd0;
            JOB_START: res = 3'd3;
            JOB_STEP:  res = 3'd7;
            default:   res = 3'd0;
        endcase
        return res;
    endfunction

    // mirror pattern for a pixel: 0 (x,y) 1 (-x,y) 2 (-x,-y) 3 (x,-y)
    // 4 (y,x) 5 (-y,x) 6 (-y,-x) 7 (y,-x); start uses 0,3,4,5 with x = 0
    function automatic logic [2:0] cor_pattern(cor_job_kind_t kind, logic [2:0] cnt);
        logic [2:0] res;
        res = cnt;
        if (kind == JOB_START) begin
            case (cnt)
                3'd0:    res = 3'd0;
                3'd1:    res = 3'd3;
                3'd2:    res = 3'd4;
                default: res = 3'd5;
            endcase
        end
        return res;
    endfunction

endpackage

FILE: rtl/circle_octant_rasterizer_top.sv
// Top level of the midpoint circle rasterizer: state update, job sequencing, output register.
// Depends on cor_pkg and cor_point.
//
// Usage:
//   s_ channel carries commands. s_tuser is func: 0 starts a circle from the
//   center and radius in s_tdata, 1 advances one octant step.
//   m_ channel carries pixels, one per transfer. m_tlast marks the final
//   pixel caused by a command, m_tuser marks the pixel that closes the circle.
// Timing:
//   The circle state is updated in the cycle a command transfers; its pixels
//   leave one per cycle while m_tready is high, from a single output
//   register, the first one having passed the job register and then the
//   output register. A start yields 4 pixels (1 for zero radius), an advance
//   yields 8, an advance with no circle active yields none. The next command
//   transfers in the cycle the previous command's last pixel is loaded, so
//   commands follow back to back.
// Reset:
//   aresetn low clears the circle state, drops any pending pixels and leaves
//   m_tvalid low. No circle is active after reset.
// Stall:
//   With m_tready low the output register holds its pixel; the pending
//   command waits, and s_tready stays low until its last pixel is loaded.
module circle_octant_rasterizer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: center_x, center_y, radius (from bit 0 up), zero padded
    input  logic [cor_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // s_tuser: func
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: point_x, point_y (from bit 0 up), zero padded
    output logic [cor_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic                               m_tlast,
    // m_tuser: done_res
    output logic                               m_tuser
);
    import cor_pkg::*;

    // command fields
    logic [COORD_BITS-1:0]  in_cx;
    logic [COORD_BITS-1:0]  in_cy;
    logic [RADIUS_BITS-1:0] in_r;

    assign in_cx = s_tdata[COORD_BITS-1:0];
    assign in_cy = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_r  = s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];

    // circle state
    logic [RADIUS_BITS-1:0] step_x_reg, step_x_next;
    logic [RADIUS_BITS-1:0] step_y_reg, step_y_next;
    logic [DEC_BITS-1:0]    dec_reg, dec_next;
    logic [COORD_BITS-1:0]  cx_reg, cx_next;
    logic [COORD_BITS-1:0]  cy_reg, cy_next;
    logic                   active_reg, active_next;

    // pending pixel job
    logic                   job_valid_reg, job_valid_next;
    cor_job_t               job_reg, job_next;

    // output register
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                     m_tlast_reg, m_tlast_next;
    logic                     m_tuser_reg, m_tuser_next;

    cor_pixel_t pixel;

    logic out_free;
    logic emit;
    logic accept;

    // octant step arithmetic
    logic [DEC_BITS-1:0]    x_ext;
    logic [DEC_BITS-1:0]    y_ext;
    logic [DEC_BITS-1:0]    r_ext;
    logic [DEC_BITS-1:0]    dec_e;
    logic [DEC_BITS-1:0]    dec_se;
    logic [DEC_BITS-1:0]    dec_start;
    logic                   dec_neg;
    logic [RADIUS_BITS-1:0] x_adv;
    logic [RADIUS_BITS-1:0] y_adv;
    logic                   fin_adv;

    cor_point u_point (
        .job      (job_reg),
        .step_x   (step_x_reg),
        .step_y   (step_y_reg),
        .center_x (cx_reg),
        .center_y (cy_reg),
        .pixel    (pixel)
    );

    // handshake: a command transfers when no job is pending or once the current job loads its last pixel
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = job_valid_reg && out_free;
    assign s_tready = !job_valid_reg || (emit && pixel.last);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        x_ext     = DEC_BITS'(step_x_reg);
        y_ext     = DEC_BITS'(step_y_reg);
        r_ext     = DEC_BITS'(in_r);
        dec_neg   = dec_reg[DEC_BITS-1];
        dec_e     = dec_reg + (x_ext << 2) + DEC_BITS'(DEC_STEP_E);
        dec_se    = dec_reg + ((x_ext - y_ext) << 2) + DEC_BITS'(DEC_STEP_SE);
        dec_start = DEC_BITS'(DEC_START) - (r_ext << 1);
        x_adv     = step_x_reg + RADIUS_BITS'(1);
        y_adv     = dec_neg ? step_y_reg : (step_y_reg - RADIUS_BITS'(1));
        fin_adv   = (x_adv >= y_adv);
    end

    always_comb begin
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        dec_next       = dec_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        active_next    = active_reg;
        job_valid_next = job_valid_reg;
        job_next       = job_reg;

        if (emit) begin
            if (pixel.last) begin
                job_valid_next = 1'b0;
            end else begin
                job_next.cnt = job_reg.cnt + 3'd1;
            end
        end

        if (accept) begin
            if (s_tuser == FUNC_START) begin
                cx_next        = in_cx;
                cy_next        = in_cy;
                step_x_next    = '0;
                step_y_next    = in_r;
                dec_next       = dec_start;
                active_next    = (in_r != '0);
                job_valid_next = 1'b1;
                job_next.kind  = (in_r == '0) ? JOB_ZERO : JOB_START;
                job_next.cnt   = 3'd0;
                job_next.fin   = 1'b0;
            end else if (active_reg) begin
                step_x_next    = x_adv;
                step_y_next    = y_adv;
                dec_next       = dec_neg ? dec_e : dec_se;
                active_next    = !fin_adv;
                job_valid_next = 1'b1;
                job_next.kind  = JOB_STEP;
                job_next.cnt   = 3'd0;
                job_next.fin   = fin_adv;
            end else begin
                // advance with no circle: nothing to draw
                job_valid_next = 1'b0;
            end
        end
    end

    // output register: loads a pixel when free or being drained
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (emit) begin
            m_tvalid_next                         = 1'b1;
            m_tdata_next                          = '0;
            m_tdata_next[OUT_BITS-1:0]            = pixel.px;
            m_tdata_next[2*OUT_BITS-1:OUT_BITS]   = pixel.py;
            m_tlast_next                          = pixel.last;
            m_tuser_next                          = pixel.done;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            dec_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            active_reg    <= 1'b0;
            job_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            dec_reg       <= dec_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            active_reg    <= active_next;
            job_valid_reg <= job_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/cor_point.sv
// Pixel generator: mirrors the current octant point about the held center.
// Depends on cor_pkg.
module cor_point (
    input  cor_pkg::cor_job_t                 job,
    input  logic [cor_pkg::RADIUS_BITS-1:0]   step_x,
    input  logic [cor_pkg::RADIUS_BITS-1:0]   step_y,
    input  logic [cor_pkg::COORD_BITS-1:0]    center_x,
    input  logic [cor_pkg::COORD_BITS-1:0]    center_y,
    output cor_pkg::cor_pixel_t               pixel
);
    import cor_pkg::*;

    logic [2:0]          pat;
    logic                swap;
    logic                neg_x;
    logic                neg_y;
    logic [OUT_BITS-1:0] off_x;
    logic [OUT_BITS-1:0] off_y;
    logic [OUT_BITS-1:0] cx_ext;
    logic [OUT_BITS-1:0] cy_ext;

    always_comb begin
        pat   = cor_pattern(job.kind, job.cnt);
        swap  = pat[2];
        neg_x = pat[1] ^ pat[0];
        neg_y = pat[1];

        off_x = swap ? OUT_BITS'(step_y) : OUT_BITS'(step_x);
        off_y = swap ? OUT_BITS'(step_x) : OUT_BITS'(step_y);

        cx_ext = {center_x[COORD_BITS-1], center_x};
        cy_ext = {center_y[COORD_BITS-1], center_y};

        pixel.px   = cx_ext + (neg_x ? -off_x : off_x);
        pixel.py   = cy_ext + (neg_y ? -off_y : off_y);
        pixel.last = (job.cnt == cor_last_cnt(job.kind));
        pixel.done = pixel.last
                   && ((job.kind == JOB_ZERO) || ((job.kind == JOB_STEP) && job.fin));
    end

endmodule

FILE: rtl/cor_checker.sv
// Port-level checks for the circle rasterizer, bound to the top level.
// Depends on cor_pkg and circle_octant_rasterizer_top.
module cor_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [cor_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    input logic                               m_tlast,
    input logic                               m_tuser
);
    import cor_pkg::*;

    // circle completion only on a command's last pixel
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("done flag on a non-final pixel");

    // stalled pixel holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output changed under stall");

    // pixels of one command leave without gaps
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside a pixel run");

    // a start transfer is followed by a valid pixel once it has passed the job and output registers
    a_start_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == FUNC_START)) |=> ##1 m_tvalid)
        else $error("start transfer gave no pixel");

endmodule

bind circle_octant_rasterizer_top cor_checker u_cor_checker (.*);
